>>> hdl/button_click_classifier_defines.svh
// Assertion helpers for the RTL.
// Each macro expects clk and arst_n in scope.
`ifndef BUTTON_CLICK_CLASSIFIER_DEFINES_SVH
`define BUTTON_CLICK_CLASSIFIER_DEFINES_SVH

// Same-cycle implication.
`define BCC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BCC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/bcc_pkg.sv
package bcc_pkg;

	localparam int unsigned TIME_W   = 32;
	localparam int unsigned CFG_W    = 16;
	localparam int unsigned CNT_W    = 8;
	localparam int unsigned CFG_ADDR_W = 2;

	localparam logic [CNT_W-1:0] CLICK_MAX = 8'd255;
	localparam logic [CNT_W-1:0] CLICK_ONE = 8'd1;
	localparam logic [CNT_W-1:0] CLICK_TWO = 8'd2;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
	localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;
	localparam logic [CFG_W-1:0] CLICK_TIME_RST = 16'd300;
	localparam logic [CFG_W-1:0] MULTI_GAP_RST  = 16'd300;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_DEBOUNCE   = 2'd0,
		REG_LONG_PRESS = 2'd1,
		REG_CLICK_TIME = 2'd2,
		REG_MULTI_GAP  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0] debounce_interval;
		logic [CFG_W-1:0] long_press_time;
		logic [CFG_W-1:0] click_time;
		logic [CFG_W-1:0] multi_click_gap;
	} cfg_t;

	typedef struct packed {
		logic [TIME_W-1:0] last_sample_time;
		logic              last_level;
		logic              pressed_flag;
		logic              long_flag;
		logic [TIME_W-1:0] press_start_time;
		logic [TIME_W-1:0] release_time;
		logic [CNT_W-1:0]  click_counter;
	} state_t;

	typedef struct packed {
		logic [CNT_W-1:0] multi_click_count;
		logic             multi_click;
		logic             double_click;
		logic             single_click;
		logic             long_held;
		logic             held;
		logic             just_released;
		logic             just_pressed;
	} result_t;

endpackage

>>> hdl/bcc_step.sv
module bcc_step (
	input  bcc_pkg::cfg_t                  cfg,
	input  bcc_pkg::state_t                st,
	input  logic                           button_active,
	input  logic [bcc_pkg::TIME_W-1:0]     now_ms,
	output bcc_pkg::state_t                st_next,
	output bcc_pkg::result_t               res
);
	import bcc_pkg::*;

	logic [TIME_W-1:0] sample_dt;
	logic [TIME_W-1:0] press_dt;
	logic [TIME_W-1:0] quiet_dt;
	logic              take;
	logic              rise;
	logic              fall;
	logic              long_hit;
	logic              click_hit;
	logic              report;
	state_t            st_edge;
	logic [CNT_W-1:0]  cnt_mid;

	// debounce gate and edge detect
	always_comb begin
		sample_dt = now_ms - st.last_sample_time;
		take      = sample_dt >= {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_interval};
		rise      = take && button_active && !st.last_level;
		fall      = take && !button_active && st.last_level;

		st_edge = st;
		if (take) begin
			st_edge.last_sample_time = now_ms;
			st_edge.last_level       = button_active;
		end
		if (rise) begin
			st_edge.pressed_flag     = 1'b1;
			st_edge.press_start_time = now_ms;
		end else if (fall) begin
			st_edge.pressed_flag = 1'b0;
			st_edge.long_flag    = 1'b0;
			st_edge.release_time = now_ms;
		end
	end

	// long press / click counting, then report after the quiet gap
	always_comb begin
		press_dt  = now_ms - st_edge.press_start_time;
		quiet_dt  = now_ms - st_edge.release_time;
		long_hit  = st_edge.pressed_flag &&
			(press_dt >= {{(TIME_W-CFG_W){1'b0}}, cfg.long_press_time});
		click_hit = fall && (press_dt <= {{(TIME_W-CFG_W){1'b0}}, cfg.click_time});

		st_next = st_edge;
		cnt_mid = st.click_counter;
		if (long_hit) begin
			st_next.long_flag = 1'b1;
			cnt_mid           = '0;
		end else if (click_hit && (st.click_counter != CLICK_MAX)) begin
			cnt_mid = st.click_counter + CLICK_ONE;
		end

		report = !st_edge.pressed_flag && (cnt_mid != '0) &&
			(quiet_dt >= {{(TIME_W-CFG_W){1'b0}}, cfg.multi_click_gap});

		res                   = '0;
		res.just_pressed      = rise;
		res.just_released     = fall;
		res.held              = st_edge.pressed_flag;
		res.long_held         = st_next.long_flag;
		st_next.click_counter = cnt_mid;
		if (report) begin
			st_next.click_counter = '0;
			if (cnt_mid == CLICK_ONE) begin
				res.single_click = 1'b1;
			end else if (cnt_mid == CLICK_TWO) begin
				res.double_click = 1'b1;
			end else begin
				res.multi_click       = 1'b1;
				res.multi_click_count = cnt_mid;
			end
		end
	end

endmodule

>>> hdl/button_click_classifier.sv
// Button debounce and click classifier. Each input transfer carries one
// sample of the pressed-level button signal and its millisecond timestamp;
// each sample yields exactly one result transfer with the debounced press
// and release edges, the held and long-press levels, and a single, double
// or multi click report (with the saturating click count for multi).
// Throughput is one sample per clock while m_tready does not hold the result.
// The sample is captured in an input register, and the state update plus
// classification happen in one pass of compare/subtract logic that writes the
// state and result registers. That state loop sets the rate. The user must
// write registers through cfg_wen/cfg_addr/cfg_wdata only while the block is
// idle; the block does not enforce this. Time differences wrap modulo 2^32.
`include "button_click_classifier_defines.svh"

module button_click_classifier (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [0] button_active, [32:1] now_ms, [39:33] zero
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [0] just_pressed, [1] just_released, [2] held,
	                               // [3] long_held, [4] single_click, [5] double_click,
	                               // [6] multi_click, [14:7] multi_click_count, [15] zero
	// configuration writes
	input  logic                               cfg_wen,
	input  logic [bcc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [bcc_pkg::CFG_W-1:0]          cfg_wdata
);
	import bcc_pkg::*;

	// input stage
	logic              valid_s1;
	logic              level_s1;
	logic [TIME_W-1:0] now_s1;

	// result stage
	logic              out_valid_q;
	result_t           res_q;

	// block state and registers
	cfg_t              cfg_q;
	state_t            st_q;
	state_t            st_next;
	result_t           res_next;

	logic              out_free;
	logic              advance;

	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	// input register frees up whenever its item moves on
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			level_s1 <= s_tdata[0];
			now_s1   <= s_tdata[TIME_W:1];
		end
	end

	bcc_step u_step (
		.cfg           (cfg_q),
		.st            (st_q),
		.button_active (level_s1),
		.now_ms        (now_s1),
		.st_next       (st_next),
		.res           (res_next)
	);

	// state advances once per sample, in step with the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_interval <= DEBOUNCE_RST;
			cfg_q.long_press_time   <= LONG_PRESS_RST;
			cfg_q.click_time        <= CLICK_TIME_RST;
			cfg_q.multi_click_gap   <= MULTI_GAP_RST;
		end else if (cfg_wen) begin
			case (reg_idx_t'(cfg_addr))
				REG_DEBOUNCE:   cfg_q.debounce_interval <= cfg_wdata;
				REG_LONG_PRESS: cfg_q.long_press_time   <= cfg_wdata;
				REG_CLICK_TIME: cfg_q.click_time        <= cfg_wdata;
				REG_MULTI_GAP:  cfg_q.multi_click_gap   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, res_q};

	// at most one click kind per result
	`BCC_ASSERT_NOW(a_one_kind, out_valid_q,
		$onehot0({res_q.single_click, res_q.double_click, res_q.multi_click}),
		"more than one click kind reported")
	// count shows only with multi, and then at least three
	`BCC_ASSERT_NOW(a_count_tie, out_valid_q,
		(res_q.multi_click ? (res_q.multi_click_count > CLICK_TWO)
			: (res_q.multi_click_count == '0)),
		"click count inconsistent with multi flag")
	// edges agree with the held level
	`BCC_ASSERT_NOW(a_edge_level, out_valid_q && (res_q.just_pressed || res_q.just_released),
		(res_q.just_pressed != res_q.just_released) &&
		(res_q.held == res_q.just_pressed),
		"press/release edge disagrees with held level")
	// long press only while held
	`BCC_ASSERT_NOW(a_long_held, out_valid_q && res_q.long_held, res_q.held,
		"long press flagged while released")
	// a click report leaves no pending clicks behind
	`BCC_ASSERT_NEXT(a_report_clears,
		advance && (res_next.single_click || res_next.double_click || res_next.multi_click),
		st_q.click_counter == '0,
		"click counter not cleared after report")

endmodule
